@@ src/nec_ir_pkg.sv @@
package nec_ir_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [TimeW-1:0] time_t;

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhAgc    = 3'd1;
  localparam logic [2:0] PhSpace  = 3'd2;
  localparam logic [2:0] PhBits   = 3'd3;
  localparam logic [2:0] PhRburst = 3'd4;
  localparam logic [2:0] PhRwait  = 3'd5;

  localparam logic [CfgIdxW-1:0] RegAgcMin       = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAgcMax       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSpaceMin     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpaceMax     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGapMin       = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGapMax       = 3'd5;
  localparam logic [CfgIdxW-1:0] RegOneMin       = 3'd6;
  localparam logic [CfgIdxW-1:0] RegResetTimeout = 3'd7;

  localparam time_t AgcMinRst       = 16'd7000;
  localparam time_t AgcMaxRst       = 16'd11000;
  localparam time_t SpaceMinRst     = 16'd3000;
  localparam time_t SpaceMaxRst     = 16'd7000;
  localparam time_t GapMinRst       = 16'd200;
  localparam time_t GapMaxRst       = 16'd3000;
  localparam time_t OneMinRst       = 16'd1000;
  localparam time_t ResetTimeoutRst = 16'd50000;

  localparam time_t ZeroMin        = 16'd200;
  localparam time_t OneMax         = 16'd3000;
  localparam time_t RepeatSpaceMin = 16'd1500;
  localparam time_t RepeatBurstMin = 16'd200;
  localparam time_t RepeatBurstMax = 16'd60000;

  typedef struct packed {
    logic             is_repeat;
    logic [WordW-1:0] word;
  } result_t;

  function automatic logic in_window(time_t t, time_t lo, time_t hi);
    in_window = (t > lo) && (t < hi);
  endfunction

endpackage

@@ src/nec_ir_pulse_decoder.sv @@
// NEC infrared frame decoder. Each input transaction is a pin edge (tuser = 0) or an idle
// check (tuser = 1), stamped with a free-running 16-bit microsecond timer; the interval
// since the last edge is taken modulo 2^16 and steps the phase machine through AGC burst,
// space, then gap mark and data space per bit, or the repeat burst. A full frame of
// FRAME_BITS bits (LSB first) yields one result with address, inverted address, command
// and inverted command in tdata bytes 0..3 and tuser = 0; a repeat code re-sends the stored
// word with tuser = 1. An idle check longer than reset_timeout returns to idle and clears
// the bit count; window errors keep the bit count. One transaction is taken every cycle
// unless the skid entry is full; a result enters the output register, or the skid entry if
// that is full: a two-entry output buffer lets input go on while one result waits. The user
// must write window registers via the cfg port while no transaction is in flight (not enforced).
module nec_ir_pulse_decoder
  import nec_ir_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // [15:0] now, [16] level, [23:17] zero
  input  logic               s_axis_tuser,   // [0] kind
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [WordW-1:0]   m_axis_tdata,   // [7:0] address, [15:8] address_inverse,
                                             // [23:16] command, [31:24] command_inverse
  output logic               m_axis_tuser    // [0] is_repeat
);

  localparam int unsigned CntW = $clog2(FRAME_BITS);
  localparam logic [CntW-1:0] LastBit = CntW'(FRAME_BITS - 1);

  time_t agc_min_q, agc_max_q, space_min_q, space_max_q;
  time_t gap_min_q, gap_max_q, one_min_q, reset_timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agc_min_q       <= AgcMinRst;
      agc_max_q       <= AgcMaxRst;
      space_min_q     <= SpaceMinRst;
      space_max_q     <= SpaceMaxRst;
      gap_min_q       <= GapMinRst;
      gap_max_q       <= GapMaxRst;
      one_min_q       <= OneMinRst;
      reset_timeout_q <= ResetTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegAgcMin:       agc_min_q       <= cfg_data_i;
        RegAgcMax:       agc_max_q       <= cfg_data_i;
        RegSpaceMin:     space_min_q     <= cfg_data_i;
        RegSpaceMax:     space_max_q     <= cfg_data_i;
        RegGapMin:       gap_min_q       <= cfg_data_i;
        RegGapMax:       gap_max_q       <= cfg_data_i;
        RegOneMin:       one_min_q       <= cfg_data_i;
        RegResetTimeout: reset_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [2:0]            phase_q, phase_d;
  logic                  expect_q, expect_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [FRAME_BITS-1:0] word_q, word_d;
  time_t                 last_q, last_d;

  logic    in_fire, kind, level, emit;
  time_t   now, dt;
  result_t res;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign kind    = s_axis_tuser;
  assign now     = s_axis_tdata[TimeW-1:0];
  assign level   = s_axis_tdata[TimeW];
  assign dt      = now - last_q;

  always_comb begin
    phase_d  = phase_q;
    expect_d = expect_q;
    cnt_d    = cnt_q;
    word_d   = word_q;
    last_d   = last_q;
    emit     = 1'b0;
    res.is_repeat = 1'b0;
    res.word      = WordW'(word_q);
    if (kind) begin
      if (dt > reset_timeout_q) begin
        phase_d  = PhIdle;
        expect_d = 1'b0;
        cnt_d    = '0;
        last_d   = now;
      end
    end else begin
      last_d = now;
      case (phase_q)
        PhIdle: begin
          if (!level) phase_d = PhAgc;
        end
        PhAgc: begin
          if (in_window(dt, agc_min_q, agc_max_q)) begin
            phase_d = PhSpace;
          end else begin
            phase_d  = PhIdle;
            expect_d = 1'b0;
          end
        end
        PhSpace: begin
          if (in_window(dt, space_min_q, space_max_q)) begin
            phase_d = PhBits;
          end else if (in_window(dt, RepeatSpaceMin, space_min_q)) begin
            phase_d = PhRburst;
          end else begin
            phase_d  = PhIdle;
            expect_d = 1'b0;
          end
        end
        PhBits: begin
          if (!expect_q) begin
            if (in_window(dt, gap_min_q, gap_max_q)) begin
              expect_d = 1'b1;
            end else begin
              phase_d  = PhIdle;
              expect_d = 1'b0;
            end
          end else if (in_window(dt, one_min_q, OneMax) ||
                       in_window(dt, ZeroMin, one_min_q)) begin
            word_d[cnt_q] = in_window(dt, one_min_q, OneMax);
            if (cnt_q == LastBit) begin
              cnt_d    = '0;
              phase_d  = PhIdle;
              expect_d = 1'b0;
              emit     = 1'b1;
              res.word = WordW'(word_d);
            end else begin
              cnt_d    = cnt_q + 1'b1;
              expect_d = 1'b0;
            end
          end else begin
            phase_d  = PhIdle;
            expect_d = 1'b0;
          end
        end
        PhRburst: begin
          emit          = 1'b1;
          res.is_repeat = 1'b1;
          if (in_window(dt, RepeatBurstMin, RepeatBurstMax)) begin
            phase_d = PhRwait;
          end else begin
            phase_d  = PhIdle;
            expect_d = 1'b0;
          end
        end
        default: begin
          phase_d  = PhIdle;
          expect_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      expect_q <= 1'b0;
      cnt_q    <= '0;
      word_q   <= '0;
      last_q   <= '0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      expect_q <= expect_d;
      cnt_q    <= cnt_d;
      word_q   <= word_d;
      last_q   <= last_d;
    end
  end

  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d, m_fire;
  result_t out_q, out_d, skid_q, skid_d;

  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (m_fire) begin
      out_valid_d  = skid_valid_q;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end
    if (in_fire && emit) begin
      if (!out_valid_d) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.word;
  assign m_axis_tuser  = out_q.is_repeat;

endmodule
